/* src/lgsi_pkg.sv */
// ----------------------------------------------------------------------------
// lgsi_pkg: shared definitions for the LOD grid/skirt index generator
// Field widths, configuration register codes, reset values and item types.
// ----------------------------------------------------------------------------
package lgsi_pkg;

    // default sizing of the block
    localparam int DEF_MAX_CELLS  = 64;
    localparam int DEF_MAX_LEVELS = 5;

    // field widths
    localparam int CELLS_W = 7;
    localparam int LOD_W   = 3;
    localparam int POS_W   = 6;
    localparam int SEG_W   = 8;
    localparam int IDX_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIRT = 1'd1;

    localparam logic [CELLS_W-1:0] CELLS_RST = 7'd16;
    localparam logic               SKIRT_RST = 1'b1;

    // primitive kinds
    localparam logic MODE_GRID  = 1'b0;
    localparam logic MODE_SKIRT = 1'b1;

    localparam logic [IDX_W-1:0] SAT_MAX = 16'hFFFF;

    // one request item
    typedef struct packed {
        logic             mode;
        logic [LOD_W-1:0] lod;
        logic [POS_W-1:0] quad_row;
        logic [POS_W-1:0] quad_col;
        logic [SEG_W-1:0] segment;
    } req_t;

    // one result item
    typedef struct packed {
        logic             valid_res;
        logic [IDX_W-1:0] index_0;
        logic [IDX_W-1:0] index_1;
        logic [IDX_W-1:0] index_2;
        logic [IDX_W-1:0] index_3;
        logic [IDX_W-1:0] index_4;
        logic [IDX_W-1:0] index_5;
        logic [IDX_W-1:0] level_offset;
        logic [IDX_W-1:0] level_count;
    } res_t;

endpackage

/* src/lgsi_req_if.sv */
// ----------------------------------------------------------------------------
// lgsi_req_if: request channel
// Valid/ready channel carrying one quad or skirt segment request per item.
// ----------------------------------------------------------------------------
interface lgsi_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [lgsi_pkg::LOD_W-1:0] lod;
    logic [lgsi_pkg::POS_W-1:0] quad_row;
    logic [lgsi_pkg::POS_W-1:0] quad_col;
    logic [lgsi_pkg::SEG_W-1:0] segment;

    modport source (output valid, mode, lod, quad_row, quad_col, segment, input ready);
    modport sink   (input valid, mode, lod, quad_row, quad_col, segment, output ready);
endinterface

/* src/lgsi_res_if.sv */
// ----------------------------------------------------------------------------
// lgsi_res_if: result channel
// Valid/ready channel carrying six indices plus level offset and count.
// ----------------------------------------------------------------------------
interface lgsi_res_if;
    logic                       valid;
    logic                       ready;
    logic                       valid_res;
    logic [lgsi_pkg::IDX_W-1:0] index_0;
    logic [lgsi_pkg::IDX_W-1:0] index_1;
    logic [lgsi_pkg::IDX_W-1:0] index_2;
    logic [lgsi_pkg::IDX_W-1:0] index_3;
    logic [lgsi_pkg::IDX_W-1:0] index_4;
    logic [lgsi_pkg::IDX_W-1:0] index_5;
    logic [lgsi_pkg::IDX_W-1:0] level_offset;
    logic [lgsi_pkg::IDX_W-1:0] level_count;

    modport source (output valid, valid_res, index_0, index_1, index_2, index_3,
                    index_4, index_5, level_offset, level_count, input ready);
    modport sink   (input valid, valid_res, index_0, index_1, index_2, index_3,
                    index_4, index_5, level_offset, level_count, output ready);
endinterface

/* src/lod_grid_skirt_index_generator.sv */
// ----------------------------------------------------------------------------
// lod_grid_skirt_index_generator: terrain chunk index generator
// Six vertex indices per quad or skirt segment, plus level offset and count.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request item (mode, lod, quad_row, quad_col, segment).
//   res returns one result item per request, in order: valid_res, six
//   indices (TL,TR,BL, BL,TR,BR for grid quads; ring/skirt pairs for skirt
//   segments), and the level's offset and count in the full index buffer.
//   cfg_we/cfg_index/cfg_data write cells_per_side and skirt_enable; write
//   them only while no request is in flight.
// Timing:
//   Two-stage pipeline: input register, then result register. An accepted
//   request enters the input register and moves on into the result register,
//   which drives res.valid; one item per cycle sustained while res.ready is high.
//   The single compute stage between the two registers holds three narrow
//   multipliers and the per-level offset adder chain.
// Stalls and reset:
//   When res.ready is low the result register holds; the input register
//   still accepts one more item, then req.ready drops until res drains.
//   Reset empties both stages and restores cells_per_side = 16 and
//   skirt_enable = 1.
// ----------------------------------------------------------------------------
module lod_grid_skirt_index_generator #(
    parameter int MAX_CELLS  = lgsi_pkg::DEF_MAX_CELLS,
    parameter int MAX_LEVELS = lgsi_pkg::DEF_MAX_LEVELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lgsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgsi_pkg::CFG_DATA_W-1:0] cfg_data,
    lgsi_req_if.sink                        req,
    lgsi_res_if.source                      res
);

    localparam int CW = lgsi_pkg::CELLS_W;
    localparam int IW = lgsi_pkg::IDX_W;
    localparam int SUM_W = 20;
    localparam logic [CW:0] MAX_C = (CW+1)'(MAX_CELLS);
    localparam logic [lgsi_pkg::LOD_W:0] MAX_L = (lgsi_pkg::LOD_W+1)'(MAX_LEVELS);

    typedef struct packed {
        logic [CW-1:0] row;
        logic [CW-1:0] col;
    } ring_pos_t;

    // ring position k to grid row/column, walking top, right, bottom, left
    function automatic ring_pos_t ring_pos(input logic [CW-1:0] c, input logic [8:0] k);
        ring_pos_t  p;
        logic [8:0] c9;
        c9 = {2'b00, c};
        if (k < c9)
        begin
            p.row = '0;
            p.col = CW'(k);
        end
        else if (k < 9'(2 * c9))
        begin
            p.row = CW'(k - c9);
            p.col = c;
        end
        else if (k < 9'(3 * c9))
        begin
            p.row = c;
            p.col = CW'(9'(3 * c9) - k);
        end
        else
        begin
            p.row = CW'(9'(4 * c9) - k);
            p.col = '0;
        end
        return p;
    endfunction

    function automatic logic [IW-1:0] sat16(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(lgsi_pkg::SAT_MAX)) ? lgsi_pkg::SAT_MAX : IW'(v);
    endfunction

    // configuration registers
    logic [CW-1:0] cells_reg;
    logic          skirt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= lgsi_pkg::CELLS_RST;
            skirt_reg <= lgsi_pkg::SKIRT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lgsi_pkg::CFG_CELLS: cells_reg <= cfg_data[CW-1:0];
                lgsi_pkg::CFG_SKIRT: skirt_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // pipeline handshake
    logic            s1_valid_reg, s1_valid_next;
    lgsi_pkg::req_t  s1_req_reg;
    logic            s2_valid_reg, s2_valid_next;
    lgsi_pkg::res_t  s2_res_reg, s2_res_next;
    logic            s2_free, s1_move, req_fire;

    assign s2_free   = !s2_valid_reg || res.ready;
    assign s1_move   = s1_valid_reg && s2_free;
    assign req.ready = !s1_valid_reg || s2_free;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        s2_valid_next = s2_valid_reg;
        if (s1_move)
            s2_valid_next = 1'b1;
        else if (res.ready)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg.mode     <= req.mode;
            s1_req_reg.lod      <= req.lod;
            s1_req_reg.quad_row <= req.quad_row;
            s1_req_reg.quad_col <= req.quad_col;
            s1_req_reg.segment  <= req.segment;
        end
    end

    // level geometry
    logic [CW-1:0]     c, steps, smask;
    logic [CW:0]       cols, s;
    logic [2*CW-1:0]   csq;
    logic              exists;
    logic [2:0]        lod;

    assign lod    = s1_req_reg.lod;
    assign c      = cells_reg;
    assign cols   = {1'b0, c} + (CW+1)'(1);
    assign s      = (CW+1)'(1) << lod;
    assign smask  = CW'(s - (CW+1)'(1));
    assign steps  = c >> lod;
    assign csq    = (2*CW)'(c) * (2*CW)'(c);
    assign exists = (c != '0) && ({1'b0, c} <= MAX_C) && ({1'b0, lod} < MAX_L)
                    && ((c & smask) == '0) && (s <= {1'b0, c});

    // offset of this level: sum of sizes of the lower levels
    logic [SUM_W-1:0] sq_sum, st_sum, off_sum, cnt_sum;

    always_comb
    begin
        sq_sum = '0;
        st_sum = '0;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (3'(l) < lod)
            begin
                sq_sum = sq_sum + SUM_W'(csq >> (2 * l));
                st_sum = st_sum + SUM_W'(c >> l);
            end
        end
        off_sum = SUM_W'(6 * sq_sum) + (skirt_reg ? SUM_W'(24 * st_sum) : '0);
        cnt_sum = SUM_W'(6 * SUM_W'(csq >> {lod, 1'b0}))
                  + (skirt_reg ? SUM_W'(24 * SUM_W'(steps)) : '0);
    end

    // grid quad corners and skirt ring positions
    logic [CW-1:0]  r0, c0;
    logic [8:0]     k, ring, k1;
    logic [9:0]     ks;
    ring_pos_t      p0, p1;
    logic [CW-1:0]  row_a, col_a;
    logic [IW-1:0]  va, vb, base, bk, bk1;
    logic           grid_ok, skirt_ok, ok;

    assign r0   = CW'(13'(s1_req_reg.quad_row) << lod);
    assign c0   = CW'(13'(s1_req_reg.quad_col) << lod);
    assign k    = 9'(15'(s1_req_reg.segment) << lod);
    assign ring = {c, 2'b00};
    assign ks   = {1'b0, k} + 10'(s);
    assign k1   = (ks >= {1'b0, ring}) ? 9'(ks - {1'b0, ring}) : ks[8:0];
    assign p0   = ring_pos(c, k);
    assign p1   = ring_pos(c, k1);

    assign grid_ok  = ({1'b0, s1_req_reg.quad_row} < steps)
                      && ({1'b0, s1_req_reg.quad_col} < steps);
    assign skirt_ok = skirt_reg && ({1'b0, s1_req_reg.segment} < {steps, 2'b00});
    assign ok       = (s1_req_reg.mode == lgsi_pkg::MODE_GRID) ? grid_ok : skirt_ok;

    // shared row multiplier: grid top-left or first ring vertex
    assign row_a = (s1_req_reg.mode == lgsi_pkg::MODE_GRID) ? r0 : p0.row;
    assign col_a = (s1_req_reg.mode == lgsi_pkg::MODE_GRID) ? c0 : p0.col;
    assign va    = IW'(IW'(row_a) * IW'(cols)) + IW'(col_a);
    assign vb    = IW'(IW'(p1.row) * IW'(cols)) + IW'(p1.col);
    assign base  = IW'(csq) + IW'({c, 1'b0}) + IW'(1);
    assign bk    = base + IW'(k);
    assign bk1   = base + IW'(k1);

    // result assembly
    always_comb
    begin
        s2_res_next = '0;
        if (exists)
        begin
            s2_res_next.valid_res    = ok;
            s2_res_next.level_offset = sat16(off_sum);
            s2_res_next.level_count  = sat16(cnt_sum);
            if (ok)
            begin
                if (s1_req_reg.mode == lgsi_pkg::MODE_GRID)
                begin
                    s2_res_next.index_0 = va;
                    s2_res_next.index_1 = va + IW'(s);
                    s2_res_next.index_2 = va + IW'(IW'(cols) << lod);
                    s2_res_next.index_3 = va + IW'(IW'(cols) << lod);
                    s2_res_next.index_4 = va + IW'(s);
                    s2_res_next.index_5 = va + IW'(IW'(cols) << lod) + IW'(s);
                end
                else
                begin
                    s2_res_next.index_0 = va;
                    s2_res_next.index_1 = vb;
                    s2_res_next.index_2 = bk;
                    s2_res_next.index_3 = bk;
                    s2_res_next.index_4 = vb;
                    s2_res_next.index_5 = bk1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_move)
            s2_res_reg <= s2_res_next;
    end

    assign res.valid        = s2_valid_reg;
    assign res.valid_res    = s2_res_reg.valid_res;
    assign res.index_0      = s2_res_reg.index_0;
    assign res.index_1      = s2_res_reg.index_1;
    assign res.index_2      = s2_res_reg.index_2;
    assign res.index_3      = s2_res_reg.index_3;
    assign res.index_4      = s2_res_reg.index_4;
    assign res.index_5      = s2_res_reg.index_5;
    assign res.level_offset = s2_res_reg.level_offset;
    assign res.level_count  = s2_res_reg.level_count;

    // checks
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("input stage lost or changed a stalled item");

    a_s2_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> s2_valid_reg)
        else $error("item moved out of input stage but result stage empty");

    a_shared_edge: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_res_reg.valid_res |->
            (s2_res_reg.index_3 == s2_res_reg.index_2)
            && (s2_res_reg.index_4 == s2_res_reg.index_1))
        else $error("triangles of one quad do not share their edge");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_res_reg.valid_res |-> s2_res_reg.level_count != '0)
        else $error("valid result from a level with no indices");

endmodule

/* dv/lod_grid_skirt_index_generator_test.sv */
// ----------------------------------------------------------------------------
// lod_grid_skirt_index_generator_test: self-checking bench for the index generator
// Drives grid quad and skirt segment requests over many cell counts and skirt
// settings, with random gaps on both channels. Every result is checked, field
// by field, against indices computed in the bench from the current settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lod_grid_skirt_index_generator_test;

    localparam int unsigned MAX_CELLS  = lgsi_pkg::DEF_MAX_CELLS;
    localparam int unsigned MAX_LEVELS = lgsi_pkg::DEF_MAX_LEVELS;
    localparam int          ITEMS_PER_PHASE = 75;
    localparam int          NUM_PHASES      = 16;

    typedef logic [lgsi_pkg::IDX_W-1:0] field_vec_t [9];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic                            cfg_we    = 1'b0;
    logic [lgsi_pkg::CFG_IDX_W-1:0]  cfg_index = lgsi_pkg::CFG_CELLS;
    logic [lgsi_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // request driver state
    logic           drv_valid = 1'b0;
    lgsi_pkg::req_t drv_item  = '0;
    int             src_wait  = 0;

    // result sink state
    logic sink_ready = 1'b0;
    int   sink_wait  = 0;

    // bench copy of the block's registers
    logic [lgsi_pkg::CELLS_W-1:0] cells_cfg = lgsi_pkg::CELLS_RST;
    logic                         skirt_cfg = lgsi_pkg::SKIRT_RST;

    // no idling on either side while set
    bit calm = 1'b0;

    lgsi_pkg::req_t pending_requests[$];
    lgsi_pkg::res_t predicted_results[$];

    int n_errors    = 0;
    int n_accepted  = 0;
    int n_in_range  = 0;
    int n_flagged   = 0;
    int n_settings  = 1;

    string field_name [9] = '{"valid_res", "index_0", "index_1", "index_2", "index_3",
                              "index_4", "index_5", "level_offset", "level_count"};

    lgsi_req_if req_ch ();
    lgsi_res_if res_ch ();

    assign req_ch.valid    = drv_valid;
    assign req_ch.mode     = drv_item.mode;
    assign req_ch.lod      = drv_item.lod;
    assign req_ch.quad_row = drv_item.quad_row;
    assign req_ch.quad_col = drv_item.quad_col;
    assign req_ch.segment  = drv_item.segment;
    assign res_ch.ready    = sink_ready;

    lod_grid_skirt_index_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    // ------------------------------------------------------------------
    // Index arithmetic
    // ------------------------------------------------------------------

    // indices in one level: grid quads plus skirt segments
    function automatic int unsigned level_len(int unsigned c, int unsigned lv, bit sk);
        int unsigned steps;
        int unsigned n;
        steps = c >> lv;
        n = steps * steps * 6;
        if (sk)
            n += steps * 24;
        return n;
    endfunction

    // grid vertex at a border ring position: top, right, bottom, left
    function automatic int unsigned ring_vertex_at(int unsigned c, int unsigned k);
        int unsigned cols;
        cols = c + 1;
        if (k < c)
            return k;
        if (k < 2 * c)
            return (k - c) * cols + c;
        if (k < 3 * c)
            return c * cols + (c - (k - 2 * c));
        return (c - (k - 3 * c)) * cols;
    endfunction

    function automatic logic [lgsi_pkg::IDX_W-1:0] sat16(int unsigned v);
        return (v > 32'hFFFF) ? lgsi_pkg::SAT_MAX : lgsi_pkg::IDX_W'(v);
    endfunction

    function automatic lgsi_pkg::res_t predict_indices(lgsi_pkg::req_t rq,
                                                       logic [lgsi_pkg::CELLS_W-1:0] cells,
                                                       logic skirt);
        lgsi_pkg::res_t r;
        int unsigned    c, lv, l, s, steps, cols, off, k, k1, base, r0, c0, tl, bl, t0, t1;
        int unsigned    ix [6];
        bit             ok;
        r  = '0;
        c  = cells;
        lv = rq.lod;
        // level missing or cell count unsupported: all zero
        if (c == 0 || c > MAX_CELLS || lv >= MAX_LEVELS)
            return r;
        s = 1 << lv;
        if ((c % s) != 0 || s > c)
            return r;
        off = 0;
        for (l = 0; l < lv; l++)
            off += level_len(c, l, skirt);
        steps = c >> lv;
        cols  = c + 1;
        ok    = 1'b0;
        ix    = '{0, 0, 0, 0, 0, 0};
        if (rq.mode == lgsi_pkg::MODE_GRID)
        begin
            if (rq.quad_row < steps && rq.quad_col < steps)
            begin
                r0 = rq.quad_row * s;
                c0 = rq.quad_col * s;
                tl = r0 * cols + c0;
                bl = (r0 + s) * cols + c0;
                ix = '{tl, tl + s, bl, bl, tl + s, bl + s};
                ok = 1'b1;
            end
        end
        else if (skirt && rq.segment < 4 * steps)
        begin
            // ring vertex paired with its skirt copy after the grid
            k    = rq.segment * s;
            k1   = (k + s) % (4 * c);
            base = cols * cols;
            t0   = ring_vertex_at(c, k);
            t1   = ring_vertex_at(c, k1);
            ix   = '{t0, t1, base + k, base + k, t1, base + k1};
            ok   = 1'b1;
        end
        r.valid_res    = ok;
        r.index_0      = lgsi_pkg::IDX_W'(ix[0]);
        r.index_1      = lgsi_pkg::IDX_W'(ix[1]);
        r.index_2      = lgsi_pkg::IDX_W'(ix[2]);
        r.index_3      = lgsi_pkg::IDX_W'(ix[3]);
        r.index_4      = lgsi_pkg::IDX_W'(ix[4]);
        r.index_5      = lgsi_pkg::IDX_W'(ix[5]);
        r.level_offset = sat16(off);
        r.level_count  = sat16(level_len(c, lv, skirt));
        return r;
    endfunction

    function automatic field_vec_t result_fields(lgsi_pkg::res_t r);
        field_vec_t f;
        f[0] = lgsi_pkg::IDX_W'(r.valid_res);
        f[1] = r.index_0;
        f[2] = r.index_1;
        f[3] = r.index_2;
        f[4] = r.index_3;
        f[5] = r.index_4;
        f[6] = r.index_5;
        f[7] = r.level_offset;
        f[8] = r.level_count;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic lgsi_pkg::req_t make_req(int mode, int lod, int row, int col, int seg);
        lgsi_pkg::req_t rq;
        rq.mode     = 1'(mode);
        rq.lod      = lgsi_pkg::LOD_W'(lod);
        rq.quad_row = lgsi_pkg::POS_W'(row);
        rq.quad_col = lgsi_pkg::POS_W'(col);
        rq.segment  = lgsi_pkg::SEG_W'(seg);
        return rq;
    endfunction

    // append one request to the driver's queue
    task automatic queue_req(lgsi_pkg::req_t rq);
        pending_requests = {pending_requests, rq};
    endtask

    // mostly in-range requests on an existing level, the rest raw noise
    function automatic lgsi_pkg::req_t random_request(int unsigned c);
        lgsi_pkg::req_t rq;
        int unsigned    levels [$];
        int unsigned    l, steps;
        rq.mode     = 1'($urandom_range(0, 1));
        rq.lod      = lgsi_pkg::LOD_W'($urandom_range(0, 7));
        rq.quad_row = lgsi_pkg::POS_W'($urandom_range(0, 63));
        rq.quad_col = lgsi_pkg::POS_W'($urandom_range(0, 63));
        rq.segment  = lgsi_pkg::SEG_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 75)
        begin
            for (l = 0; l < MAX_LEVELS; l++)
                if (c != 0 && c <= MAX_CELLS && (c % (1 << l)) == 0 && (1 << l) <= c)
                    levels = {levels, l};
            if (levels.size() != 0)
            begin
                rq.lod      = lgsi_pkg::LOD_W'(levels[$urandom_range(0, levels.size() - 1)]);
                steps       = c >> rq.lod;
                rq.quad_row = lgsi_pkg::POS_W'($urandom_range(0, steps - 1));
                rq.quad_col = lgsi_pkg::POS_W'($urandom_range(0, steps - 1));
                rq.segment  = lgsi_pkg::SEG_W'($urandom_range(0, 4 * steps - 1));
            end
        end
        return rq;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int idle_cycles();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() != 0 || drv_valid || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(logic [lgsi_pkg::CFG_IDX_W-1:0] idx,
                                  logic [lgsi_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == lgsi_pkg::CFG_CELLS)
            cells_cfg = lgsi_pkg::CELLS_W'(data);
        else
            skirt_cfg = data[0];
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            src_wait  <= 0;
        end
        else if (!drv_valid || req_ch.ready)
        begin
            if (src_wait != 0)
            begin
                drv_valid <= 1'b0;
                src_wait  <= src_wait - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                drv_item  <= pending_requests.pop_front();
                drv_valid <= 1'b1;
                src_wait  <= idle_cycles();
            end
            else
            begin
                drv_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls on ready
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            sink_wait  <= 0;
        end
        else if (sink_wait != 0)
        begin
            sink_ready <= 1'b0;
            sink_wait  <= sink_wait - 1;
        end
        else
        begin
            sink_ready <= 1'b1;
            sink_wait  <= idle_cycles();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict for accepted requests
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        lgsi_pkg::res_t seen;
        lgsi_pkg::res_t want;
        field_vec_t     seen_f;
        field_vec_t     want_f;
        if (rst_n && res_ch.valid && sink_ready)
        begin
            seen.valid_res    = res_ch.valid_res;
            seen.index_0      = res_ch.index_0;
            seen.index_1      = res_ch.index_1;
            seen.index_2      = res_ch.index_2;
            seen.index_3      = res_ch.index_3;
            seen.index_4      = res_ch.index_4;
            seen.index_5      = res_ch.index_5;
            seen.level_offset = res_ch.level_offset;
            seen.level_count  = res_ch.level_count;
            seen_f = result_fields(seen);
            if (predicted_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got valid_res %0d offset %0d",
                         $time, seen.valid_res, seen.level_offset);
            end
            else
            begin
                want   = predicted_results.pop_front();
                want_f = result_fields(want);
                if (want.valid_res)
                    n_in_range++;
                else
                    n_flagged++;
                for (int i = 0; i < 9; i++)
                    if (seen_f[i] !== want_f[i])
                    begin
                        n_errors++;
                        $display("%0t: %s mismatch, expected %0d, got %0d",
                                 $time, field_name[i], want_f[i], seen_f[i]);
                    end
            end
        end
        if (rst_n && drv_valid && req_ch.ready)
        begin
            predicted_results = {predicted_results,
                                 predict_indices(drv_item, cells_cfg, skirt_cfg)};
            n_accepted++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned cells_tab [12];
        bit          skirt_tab [12];
        int unsigned c;
        bit          sk;
        cells_tab = '{64, 64, 1, 1, 0, 127, 65, 12, 48, 7, 32, 24};
        skirt_tab = '{1, 0, 1, 0, 1, 0, 1, 1, 0, 1, 1, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 16 cells, skirts on
        queue_req(make_req(lgsi_pkg::MODE_GRID, 0, 0, 0, 0));
        queue_req(make_req(lgsi_pkg::MODE_GRID, 0, 15, 15, 255));
        queue_req(make_req(lgsi_pkg::MODE_GRID, 0, 16, 0, 0));     // row past edge
        queue_req(make_req(lgsi_pkg::MODE_GRID, 0, 0, 63, 0));     // col past edge
        queue_req(make_req(lgsi_pkg::MODE_GRID, 4, 0, 0, 0));      // single quad level
        queue_req(make_req(lgsi_pkg::MODE_GRID, 4, 0, 1, 0));
        queue_req(make_req(lgsi_pkg::MODE_GRID, 5, 0, 0, 0));      // beyond level count
        queue_req(make_req(lgsi_pkg::MODE_GRID, 7, 63, 63, 255));
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 0));
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 63, 63, 16));  // right side start
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 47));    // bottom side end
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 63));    // ring wraps
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 64));    // past ring end
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 255));
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 2, 0, 0, 15));    // wrap at stride 4
        queue_req(make_req(lgsi_pkg::MODE_SKIRT, 6, 0, 0, 0));
        // sender holds off until the pipeline is empty
        wait_drained();
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_req(random_request(cells_cfg));
        wait_drained();

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            if (p <= 12)
            begin
                c  = cells_tab[p-1];
                sk = skirt_tab[p-1];
            end
            else
            begin
                c  = $urandom_range(1, 64);
                sk = 1'($urandom_range(0, 1));
            end
            calm = ($urandom_range(0, 3) == 0);
            // pipeline is empty; allow the two stages to settle
            repeat (4) @(posedge clk);
            write_register(lgsi_pkg::CFG_CELLS, lgsi_pkg::CFG_DATA_W'(c));
            write_register(lgsi_pkg::CFG_SKIRT, {6'($urandom_range(0, 63)), sk});
            n_settings++;
            @(negedge clk);
            case (p)
                1:
                begin
                    queue_req(make_req(lgsi_pkg::MODE_GRID, 0, 63, 63, 0));
                    queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 255));
                    queue_req(make_req(lgsi_pkg::MODE_GRID, 4, 3, 3, 0));
                    queue_req(make_req(lgsi_pkg::MODE_SKIRT, 4, 0, 0, 15));
                end
                2:
                begin
                    // skirt request with skirts off
                    queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 0));
                    queue_req(make_req(lgsi_pkg::MODE_GRID, 1, 31, 31, 0));
                end
                3:
                begin
                    queue_req(make_req(lgsi_pkg::MODE_GRID, 0, 0, 0, 0));
                    queue_req(make_req(lgsi_pkg::MODE_GRID, 1, 0, 0, 0)); // stride > cells
                    queue_req(make_req(lgsi_pkg::MODE_SKIRT, 0, 0, 0, 3));
                end
                8:
                begin
                    // stride 8 does not divide 12
                    queue_req(make_req(lgsi_pkg::MODE_GRID, 3, 0, 0, 0));
                    queue_req(make_req(lgsi_pkg::MODE_SKIRT, 2, 0, 0, 11));
                end
                default: ;
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                queue_req(random_request(c));
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d requests over %0d register settings: %0d in range, %0d flagged.",
                 n_accepted, n_settings, n_in_range, n_flagged);
        $display("Cell counts 0..127 incl. odd and unsupported sizes, skirts on and off.");
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
